@@ hdl/usbncm_pkg.sv @@
package usbncm_pkg;

	localparam int MAX_ENTRIES_DEF  = 22;
	localparam int HEADER_FLOOR_DEF = 108;

	localparam logic [31:0] NTH_SIGN = 32'h484D_434E;
	localparam logic [31:0] NDP_SIGN = 32'h304D_434E;
	localparam logic [15:0] NTH_LEN  = 16'd12;
	localparam logic [15:0] NDP_MIN  = 16'd12;
	localparam logic [15:0] CTRL_SIG = 16'h0100;
	localparam logic [15:0] MIN_LEN  = 16'd4;
	localparam logic [15:0] ETH_HDR  = 16'd14;

	localparam logic [15:0] ET_ARP  = 16'h0806;
	localparam logic [15:0] ET_IPV4 = 16'h0800;
	localparam logic [15:0] ET_IPV6 = 16'h86DD;

	localparam logic [15:0] LEG_OFFSET  = 16'd2;
	localparam logic [15:0] ARP_LEN     = 16'd42;
	localparam logic [15:0] IPV4_MIN    = 16'd34;
	localparam logic [15:0] IPV6_MIN    = 16'd54;
	localparam logic [15:0] IHL_MIN     = 16'd20;
	localparam logic [15:0] CTRL_ANN    = 16'd4;

	localparam logic KIND_FRAME  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic        desc_v;
		logic [15:0] frame_offset;
		logic [15:0] frame_length;
		logic        stat_v;
		logic        buffer_ok;
		logic [4:0]  frames_found;
		logic [15:0] announced_length;
	} cmd_t;

endpackage

@@ hdl/usbncm_if.sv @@
interface usbncm_byte_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [15:0] buffer_length;
	logic        last_byte;

	modport source (output valid, data_byte, buffer_length, last_byte, input ready);
	modport sink (input valid, data_byte, buffer_length, last_byte, output ready);
endinterface

interface usbncm_res_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [15:0] frame_offset;
	logic [15:0] frame_length;
	logic        buffer_ok;
	logic [4:0]  frames_found;
	logic [15:0] announced_length;
	logic        end_of_run;

	modport source (output valid, result_kind, frame_offset, frame_length, buffer_ok,
		frames_found, announced_length, end_of_run, input ready);
	modport sink (input valid, result_kind, frame_offset, frame_length, buffer_ok,
		frames_found, announced_length, end_of_run, output ready);
endinterface

interface usbncm_cfg_if;
	logic valid;
	logic ready;
	logic ncm_mode;

	modport source (output valid, ncm_mode, input ready);
	modport sink (input valid, ncm_mode, output ready);
endinterface

@@ hdl/usbncm_front.sv @@
module usbncm_front
	import usbncm_pkg::*;
#(
	parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
	parameter int HEADER_FLOOR = HEADER_FLOOR_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	usbncm_byte_if.sink   rx,
	usbncm_cfg_if.sink    cfg,
	input  logic          space,
	output logic          push,
	output cmd_t          push_cmd
);

	localparam int EW = $clog2(MAX_ENTRIES + 1);
	localparam logic [15:0] FLOOR = 16'(HEADER_FLOOR);

	logic          ncm_q;
	logic [15:0]   pos_q, pos_n;
	logic          decided_q, decided_n;
	logic [31:0]   sig_q, sig_n;
	logic [31:0]   entry_q, entry_n;
	logic [15:0]   len_q, len_n;
	logic [15:0]   blk_q, blk_n;
	logic [EW-1:0] ecnt_q, ecnt_n;
	logic [EW-1:0] elim_q, elim_n;
	logic [EW-1:0] tally_q, tally_n;
	logic [15:0]   et_q, et_n;
	logic [5:0]    ihl_q, ihl_n;
	logic [15:0]   fcap_q, fcap_n;

	logic          acc;
	cmd_t          cmd;
	logic [15:0]   lo16, be16, idx, flen;
	logic [16:0]   sum17;
	logic [13:0]   avail;
	logic [5:0]    ihl;
	logic [EW:0]   ecnt_inc;
	logic [EW+4:0] tally_ext;

	assign rx.ready  = space;
	assign cfg.ready = 1'b1;
	assign acc       = rx.valid && rx.ready;
	assign push      = acc && (cmd.desc_v || cmd.stat_v);
	assign push_cmd  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncm_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			ncm_q <= cfg.ncm_mode;
		end
	end

	always_comb begin
		cmd       = '0;
		pos_n     = pos_q;
		decided_n = decided_q;
		sig_n     = sig_q;
		entry_n   = entry_q;
		len_n     = len_q;
		blk_n     = blk_q;
		ecnt_n    = ecnt_q;
		elim_n    = elim_q;
		tally_n   = tally_q;
		et_n      = et_q;
		ihl_n     = ihl_q;
		fcap_n    = fcap_q;
		lo16      = '0;
		be16      = '0;
		idx       = entry_q[15:0];
		flen      = entry_q[31:16];
		sum17     = '0;
		avail     = '0;
		ihl       = '0;
		ecnt_inc  = {1'b0, ecnt_q} + 1'b1;
		tally_ext = {5'b0, tally_q};
		if (acc) begin
			if (!decided_q) begin
				sig_n = {rx.data_byte, sig_q[31:8]};
				lo16  = sig_n[31:16];
				be16  = {sig_n[23:16], sig_n[31:24]};
				if (pos_q >= 16'd20) begin
					entry_n = {rx.data_byte, entry_q[31:8]};
				end
				idx  = entry_n[15:0];
				flen = entry_n[31:16];
				if (pos_q == 16'd0) begin
					len_n = rx.buffer_length;
					if (rx.buffer_length < MIN_LEN) begin
						cmd.stat_v = 1'b1;
						decided_n  = 1'b1;
					end
				end else if (pos_q < 16'd3) begin
					decided_n = decided_q;
				end else if (pos_q == 16'd3) begin
					decided_n = 1'b1;
					cmd.stat_v = 1'b1;
					if (ncm_q && sig_n == '0) begin
						cmd.buffer_ok = 1'b1;
					end else if (sig_n[15:0] == CTRL_SIG) begin
						cmd.buffer_ok        = 1'b1;
						cmd.announced_length = CTRL_ANN;
					end else if (ncm_q) begin
						if (len_q >= FLOOR && sig_n == NTH_SIGN) begin
							cmd.stat_v = 1'b0;
							decided_n  = 1'b0;
						end
					end else if (len_q >= ETH_HDR + LEG_OFFSET) begin
						cmd.stat_v = 1'b0;
						decided_n  = 1'b0;
						fcap_n     = len_q - LEG_OFFSET;
					end
				end else if (ncm_q) begin
					if (pos_q == 16'd5) begin
						cmd.stat_v = (lo16 != NTH_LEN);
					end else if (pos_q == 16'd9) begin
						cmd.stat_v = (lo16 < FLOOR) || (lo16 > len_q);
						blk_n      = cmd.stat_v ? blk_q : lo16;
					end else if (pos_q == 16'd11) begin
						cmd.stat_v = (lo16 != NTH_LEN);
					end else if (pos_q == 16'd15) begin
						cmd.stat_v = (sig_n != NDP_SIGN);
					end else if (pos_q == 16'd17) begin
						sum17 = {1'b0, NTH_LEN} + {1'b0, lo16};
						if (lo16 < NDP_MIN || sum17 > {1'b0, blk_q}) begin
							cmd.stat_v = 1'b1;
						end else begin
							avail   = 14'((lo16 - 16'd8) >> 2);
							elim_n  = (avail < 14'(MAX_ENTRIES)) ? avail[EW-1:0]
								: EW'(MAX_ENTRIES);
							ecnt_n  = '0;
							tally_n = '0;
						end
					end else if (pos_q >= 16'd23 && pos_q[1:0] == 2'd3 && ecnt_q < elim_q) begin
						if (idx == '0 && flen == '0) begin
							cmd.stat_v           = 1'b1;
							cmd.buffer_ok        = 1'b1;
							cmd.frames_found     = tally_ext[4:0];
							cmd.announced_length = blk_q;
						end else if (idx < FLOOR || idx >= blk_q || flen < ETH_HDR
							|| flen > blk_q - idx) begin
							cmd.stat_v = 1'b1;
						end else begin
							cmd.desc_v       = 1'b1;
							cmd.frame_offset = idx;
							cmd.frame_length = flen;
							tally_n          = tally_q + 1'b1;
							ecnt_n           = ecnt_inc[EW-1:0];
							cmd.stat_v       = (ecnt_inc >= {1'b0, elim_q});
						end
					end
					decided_n = cmd.stat_v;
				end else begin
					if (pos_q == 16'd15) begin
						et_n = be16;
						if (be16 == ET_ARP) begin
							cmd.stat_v = 1'b1;
							if (fcap_q >= ARP_LEN) begin
								cmd.desc_v           = 1'b1;
								cmd.frame_offset     = LEG_OFFSET;
								cmd.frame_length     = ARP_LEN;
								cmd.buffer_ok        = 1'b1;
								cmd.frames_found     = 5'd1;
								cmd.announced_length = ARP_LEN + LEG_OFFSET;
							end
						end else if (!((be16 == ET_IPV4 && fcap_q >= IPV4_MIN)
							|| (be16 == ET_IPV6 && fcap_q >= IPV6_MIN))) begin
							cmd.stat_v = 1'b1;
						end
					end else if (pos_q == 16'd16 && et_q == ET_IPV4) begin
						ihl   = {rx.data_byte[3:0], 2'b00};
						sum17 = {1'b0, ETH_HDR} + 17'(ihl);
						cmd.stat_v = (16'(ihl) < IHL_MIN) || ({1'b0, fcap_q} < sum17);
						ihl_n = cmd.stat_v ? ihl_q : ihl;
					end else if (pos_q == 16'd19 && et_q == ET_IPV4) begin
						sum17 = {1'b0, ETH_HDR} + {1'b0, be16};
						cmd.stat_v = 1'b1;
						if (!(be16 < 16'(ihl_q) || sum17 > {1'b0, fcap_q})) begin
							cmd.desc_v           = 1'b1;
							cmd.frame_offset     = LEG_OFFSET;
							cmd.frame_length     = sum17[15:0];
							cmd.buffer_ok        = 1'b1;
							cmd.frames_found     = 5'd1;
							cmd.announced_length = sum17[15:0] + LEG_OFFSET;
						end
					end else if (pos_q == 16'd21 && et_q == ET_IPV6) begin
						sum17 = {1'b0, IPV6_MIN} + {1'b0, be16};
						cmd.stat_v = 1'b1;
						if (sum17 <= {1'b0, fcap_q}) begin
							cmd.desc_v           = 1'b1;
							cmd.frame_offset     = LEG_OFFSET;
							cmd.frame_length     = sum17[15:0];
							cmd.buffer_ok        = 1'b1;
							cmd.frames_found     = 5'd1;
							cmd.announced_length = sum17[15:0] + LEG_OFFSET;
						end
					end
					decided_n = cmd.stat_v;
				end
			end
			if (rx.last_byte) begin
				if (!decided_q && !cmd.stat_v) begin
					cmd.stat_v = 1'b1;
				end
				pos_n     = '0;
				decided_n = 1'b0;
				sig_n     = '0;
				entry_n   = '0;
				len_n     = '0;
				blk_n     = '0;
				ecnt_n    = '0;
				elim_n    = '0;
				tally_n   = '0;
				et_n      = '0;
				ihl_n     = '0;
				fcap_n    = '0;
			end else if (pos_q != 16'hFFFF) begin
				pos_n = pos_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			decided_q <= 1'b0;
			sig_q     <= '0;
			entry_q   <= '0;
			len_q     <= '0;
			blk_q     <= '0;
			ecnt_q    <= '0;
			elim_q    <= '0;
			tally_q   <= '0;
			et_q      <= '0;
			ihl_q     <= '0;
			fcap_q    <= '0;
		end else begin
			pos_q     <= pos_n;
			decided_q <= decided_n;
			sig_q     <= sig_n;
			entry_q   <= entry_n;
			len_q     <= len_n;
			blk_q     <= blk_n;
			ecnt_q    <= ecnt_n;
			elim_q    <= elim_n;
			tally_q   <= tally_n;
			et_q      <= et_n;
			ihl_q     <= ihl_n;
			fcap_q    <= fcap_n;
		end
	end

endmodule

@@ hdl/usbncm_queue.sv @@
module usbncm_queue
	import usbncm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic space,
	input  logic pop,
	output logic head_valid,
	output cmd_t head
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign space      = (count_q != CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/usbncm_back.sv @@
module usbncm_back
	import usbncm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         head_valid,
	input  cmd_t         head,
	output logic         pop,
	usbncm_res_if.source res
);

	logic        valid_q;
	logic        desc_done_q;
	logic        kind_q;
	logic [15:0] off_q;
	logic [15:0] len_q;
	logic        ok_q;
	logic [4:0]  cnt_q;
	logic [15:0] ann_q;
	logic        load;
	logic        send_desc;

	assign load      = head_valid && (!valid_q || res.ready);
	assign send_desc = head.desc_v && !desc_done_q;
	assign pop       = load && !(send_desc && head.stat_v);

	assign res.valid            = valid_q;
	assign res.result_kind      = kind_q;
	assign res.frame_offset     = off_q;
	assign res.frame_length     = len_q;
	assign res.buffer_ok        = ok_q;
	assign res.frames_found     = cnt_q;
	assign res.announced_length = ann_q;
	assign res.end_of_run       = kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			desc_done_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q     <= 1'b1;
				desc_done_q <= send_desc && head.stat_v;
			end else if (res.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (send_desc) begin
				kind_q <= KIND_FRAME;
				off_q  <= head.frame_offset;
				len_q  <= head.frame_length;
				ok_q   <= 1'b0;
				cnt_q  <= '0;
				ann_q  <= '0;
			end else begin
				kind_q <= KIND_STATUS;
				off_q  <= '0;
				len_q  <= '0;
				ok_q   <= head.buffer_ok;
				cnt_q  <= head.frames_found;
				ann_q  <= head.announced_length;
			end
		end
	end

endmodule

@@ hdl/usb_ncm_rx_deframer.sv @@
// channel | modport | transaction
// rx      | sink    | one buffer byte with buffer length and last flag
// cfg     | sink    | write of ncm_mode
// res     | source  | frame descriptor or buffer status
//
// One byte is taken per cycle while the result queue has space; the parse state updates in the cycle of acceptance.
// A byte yields at most two results, queued (4 entries) and sent one per cycle while res.ready is high.
// rx.ready drops only while the result queue is full; cfg.ready is always high.
// arst_n clears the parse state, queue pointers and output valid; ncm_mode resets to 0.
module usb_ncm_rx_deframer
	import usbncm_pkg::*;
#(
	parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
	parameter int HEADER_FLOOR = HEADER_FLOOR_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	usbncm_byte_if.sink  rx,
	usbncm_cfg_if.sink   cfg,
	usbncm_res_if.source res
);

	logic space;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head;

	usbncm_front #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.HEADER_FLOOR (HEADER_FLOOR)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.cfg      (cfg),
		.space    (space),
		.push     (push),
		.push_cmd (push_cmd)
	);

	usbncm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.space      (space),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	usbncm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res        (res)
	);

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import usbncm_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int RANDOM_ITEMS   = 350;
	localparam int STUCK_BYTES    = 48;
	localparam int MIN_BLOCK      = HEADER_FLOOR_DEF + 14;

	typedef enum int {PROTO_ARP, PROTO_IPV4, PROTO_IPV6, PROTO_OTHER} frame_proto_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] offset;
		logic [15:0] length;
		logic        ok;
		logic [4:0]  count;
		logic [15:0] announced;
		logic        run_end;
	} deframer_result_t;

	logic clk;
	logic arst_n;

	usbncm_byte_if rx_if ();
	usbncm_cfg_if  cfg_if ();
	usbncm_res_if  res_if ();

	usb_ncm_rx_deframer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.cfg    (cfg_if),
		.res    (res_if)
	);

	deframer_result_t pending_results[$];
	int errors = 0;
	int quiet_cycles = 0;
	bit rx_idle_on;
	bit res_stall_on;

	logic [7:0]  buf_q[$];
	logic [15:0] buf_len;

	// parser shadow state
	bit          mode_shadow;
	logic [15:0] pos_q;
	bit          done_q;
	logic [31:0] sig_q;
	logic [15:0] cap_q;
	logic [15:0] blk_q;
	logic [15:0] entry_count_q;
	logic [31:0] entry_q;
	int unsigned limit_q;
	int unsigned tally_q;
	logic [15:0] ethertype_q;
	logic [15:0] ihl_q;
	logic [15:0] fcap_q;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_parser();
		pos_q = '0;
		done_q = 1'b0;
		sig_q = '0;
		cap_q = '0;
		blk_q = '0;
		entry_count_q = '0;
		entry_q = '0;
		limit_q = 0;
		tally_q = 0;
		ethertype_q = '0;
		ihl_q = '0;
		fcap_q = '0;
	endfunction

	function automatic void push_result(logic kind, int unsigned off, int unsigned len,
			bit ok, int unsigned cnt, int unsigned ann);
		deframer_result_t r;
		r.kind = kind;
		r.offset = 16'(off);
		r.length = 16'(len);
		r.ok = ok;
		r.count = 5'(cnt);
		r.announced = 16'(ann);
		r.run_end = kind;
		pending_results.push_back(r);
	endfunction

	function automatic void push_status(bit ok, int unsigned cnt, int unsigned ann);
		done_q = 1'b1;
		push_result(KIND_STATUS, 0, 0, ok, ok ? cnt : 0, ok ? ann : 0);
	endfunction

	function automatic void ncm_step(int unsigned pos);
		int unsigned lo16, blk, idx, len, avail;
		lo16 = 32'(sig_q[31:16]);
		blk = 32'(blk_q);
		if (pos == 5) begin
			if (lo16 != NTH_LEN) push_status(0, 0, 0);
		end else if (pos == 9) begin
			if (lo16 < HEADER_FLOOR_DEF || lo16 > cap_q) push_status(0, 0, 0);
			else blk_q = 16'(lo16);
		end else if (pos == 11) begin
			if (lo16 != NTH_LEN) push_status(0, 0, 0);
		end else if (pos == 15) begin
			if (sig_q != NDP_SIGN) push_status(0, 0, 0);
		end else if (pos == 17) begin
			if (lo16 < NDP_MIN || 32'(NTH_LEN) + lo16 > blk) begin
				push_status(0, 0, 0);
			end else begin
				avail = (lo16 - 8) / 4;
				limit_q = (avail < MAX_ENTRIES_DEF) ? avail : 32'(MAX_ENTRIES_DEF);
				entry_count_q = '0;
				tally_q = 0;
			end
		end else if (pos >= 23 && (pos - 23) % 4 == 0 && entry_count_q < limit_q) begin
			idx = 32'(entry_q[15:0]);
			len = 32'(entry_q[31:16]);
			if (idx == 0 && len == 0) begin
				push_status(1, tally_q, blk);
			end else if (idx < HEADER_FLOOR_DEF || idx >= blk || len < ETH_HDR
					|| len > blk - idx) begin
				push_status(0, 0, 0);
			end else begin
				push_result(KIND_FRAME, idx, len, 0, 0, 0);
				tally_q++;
				entry_count_q++;
				if (entry_count_q >= limit_q) push_status(0, 0, 0);
			end
		end
	endfunction

	function automatic void legacy_step(int unsigned pos, logic [7:0] b);
		int unsigned be16, et, fcap, ihl;
		be16 = 32'({sig_q[23:16], sig_q[31:24]});
		et = 32'(ethertype_q);
		fcap = 32'(fcap_q);
		ihl = 32'(ihl_q);
		if (pos == 15) begin
			ethertype_q = 16'(be16);
			if (be16 == ET_ARP) begin
				if (fcap < ARP_LEN) begin
					push_status(0, 0, 0);
				end else begin
					push_result(KIND_FRAME, 32'(LEG_OFFSET), 32'(ARP_LEN), 0, 0, 0);
					push_status(1, 1, 32'(ARP_LEN) + 32'(LEG_OFFSET));
				end
			end else if (!(be16 == ET_IPV4 && fcap >= IPV4_MIN)
					&& !(be16 == ET_IPV6 && fcap >= IPV6_MIN)) begin
				push_status(0, 0, 0);
			end
		end else if (pos == 16 && et == ET_IPV4) begin
			ihl = int'(b[3:0]) * 4;
			if (ihl < IHL_MIN || fcap < 32'(ETH_HDR) + ihl) push_status(0, 0, 0);
			else ihl_q = 16'(ihl);
		end else if (pos == 19 && et == ET_IPV4) begin
			if (be16 < ihl || 32'(ETH_HDR) + be16 > fcap) begin
				push_status(0, 0, 0);
			end else begin
				push_result(KIND_FRAME, 32'(LEG_OFFSET), 32'(ETH_HDR) + be16, 0, 0, 0);
				push_status(1, 1, 32'(ETH_HDR) + 32'(LEG_OFFSET) + be16);
			end
		end else if (pos == 21 && et == ET_IPV6) begin
			if (32'(IPV6_MIN) + be16 > fcap) begin
				push_status(0, 0, 0);
			end else begin
				push_result(KIND_FRAME, 32'(LEG_OFFSET), 32'(IPV6_MIN) + be16, 0, 0, 0);
				push_status(1, 1, 32'(IPV6_MIN) + 32'(LEG_OFFSET) + be16);
			end
		end
	endfunction

	function automatic void parse_byte(logic [7:0] b, logic [15:0] blen, bit lst);
		int unsigned pos, cap;
		pos = 32'(pos_q);
		if (!done_q) begin
			sig_q = {b, sig_q[31:8]};
			if (pos >= 20) entry_q = {b, entry_q[31:8]};
			if (pos == 0) cap_q = blen;
			cap = 32'(cap_q);
			if (pos == 0 && blen < MIN_LEN) begin
				push_status(0, 0, 0);
			end else if (pos == 3) begin
				if (mode_shadow && sig_q == '0) begin
					push_status(1, 0, 0);
				end else if (sig_q[15:0] == CTRL_SIG) begin
					push_status(1, 0, 32'(CTRL_ANN));
				end else if (mode_shadow) begin
					if (cap < HEADER_FLOOR_DEF || sig_q != NTH_SIGN) push_status(0, 0, 0);
				end else if (cap - 2 < ETH_HDR) begin
					push_status(0, 0, 0);
				end else begin
					fcap_q = 16'(cap - 2);
				end
			end else if (pos > 3) begin
				if (mode_shadow) ncm_step(pos);
				else legacy_step(pos, b);
			end
		end
		if (lst) begin
			if (!done_q) push_status(0, 0, 0);
			clear_parser();
		end else if (pos_q != 16'hFFFF) begin
			pos_q++;
		end
	endfunction

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	initial begin : result_sink
		deframer_result_t want;
		int unsigned stall;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = res_stall_on ? $urandom_range(0, 15) : 0;
			if (stall != 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (res_if.valid !== 1'b1);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, kind %0d off %0d len %0d ok %0d",
					$time, res_if.result_kind, res_if.frame_offset, res_if.frame_length,
					res_if.buffer_ok);
				errors++;
			end else begin
				want = pending_results.pop_front();
				compare_field("result_kind", 16'(want.kind), 16'(res_if.result_kind));
				compare_field("frame_offset", want.offset, res_if.frame_offset);
				compare_field("frame_length", want.length, res_if.frame_length);
				compare_field("buffer_ok", 16'(want.ok), 16'(res_if.buffer_ok));
				compare_field("frames_found", 16'(want.count), 16'(res_if.frames_found));
				compare_field("announced_length", want.announced, res_if.announced_length);
				compare_field("end_of_run", 16'(want.run_end), 16'(res_if.end_of_run));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)
				|| (cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
				pending_results.size());
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic [15:0] blen, input bit lst);
		int unsigned gap;
		gap = rx_idle_on ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.data_byte <= b;
		rx_if.buffer_length <= blen;
		rx_if.last_byte <= lst;
		do @(posedge clk); while (rx_if.ready !== 1'b1);
		parse_byte(b, blen, lst);
	endtask

	task automatic send_buffer(input bit mark_last);
		foreach (buf_q[i]) send_byte(buf_q[i], buf_len, mark_last && i == buf_q.size() - 1);
	endtask

	// also lowers valid in the step of the last transaction
	task automatic wait_idle();
		rx_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input bit ncm);
		cfg_if.ncm_mode <= ncm;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		mode_shadow = ncm;
		cfg_if.valid <= 1'b0;
	endtask

	function automatic void put16(int unsigned v);
		buf_q.push_back(v[7:0]);
		buf_q.push_back(v[15:8]);
	endfunction

	function automatic void build_ncm(int unsigned entries, bit terminated,
			int unsigned blk, int unsigned cap);
		int unsigned ndp, idx, len;
		buf_q.delete();
		buf_len = 16'(cap);
		put16(32'(NTH_SIGN[15:0]));
		put16(32'(NTH_SIGN[31:16]));
		put16(32'(NTH_LEN));
		put16($urandom);
		put16(blk);
		put16(32'(NTH_LEN));
		put16(32'(NDP_SIGN[15:0]));
		put16(32'(NDP_SIGN[31:16]));
		ndp = 8 + 4 * (entries + terminated);
		if (terminated) ndp += 4 * $urandom_range(0, 2);
		put16(ndp);
		put16($urandom);
		repeat (entries) begin
			if ($urandom_range(0, 7) == 0) idx = HEADER_FLOOR_DEF;
			else idx = $urandom_range(HEADER_FLOOR_DEF, blk - ETH_HDR);
			case ($urandom_range(0, 3))
				0: len = 32'(ETH_HDR);
				1: len = blk - idx;
				default: len = $urandom_range(ETH_HDR, blk - idx);
			endcase
			put16(idx);
			put16(len);
		end
		if (terminated) begin
			put16(0);
			put16(0);
		end
		repeat ($urandom_range(0, 3)) buf_q.push_back(8'($urandom));
	endfunction

	function automatic void build_legacy(frame_proto_t proto, int unsigned payload,
			int unsigned slack);
		int unsigned et, tl, cap, ihl_words;
		buf_q.delete();
		repeat (14) buf_q.push_back(8'($urandom));
		ihl_words = $urandom_range(5, 15);
		tl = payload;
		case (proto)
			PROTO_ARP: begin
				et = 32'(ET_ARP);
				cap = 32'(ARP_LEN) + 32'(LEG_OFFSET) + slack;
			end
			PROTO_IPV4: begin
				et = 32'(ET_IPV4);
				tl = payload + ihl_words * 4;
				cap = 32'(ETH_HDR) + 32'(LEG_OFFSET) + tl + slack;
			end
			PROTO_IPV6: begin
				et = 32'(ET_IPV6);
				cap = 32'(IPV6_MIN) + 32'(LEG_OFFSET) + tl + slack;
			end
			default: begin
				et = $urandom_range(0, 65535);
				cap = $urandom_range(4, 65535);
			end
		endcase
		buf_q.push_back(et[15:8]);
		buf_q.push_back(et[7:0]);
		if (proto == PROTO_IPV4) begin
			buf_q.push_back({4'h4, ihl_words[3:0]});
			buf_q.push_back(8'($urandom));
			buf_q.push_back(tl[15:8]);
			buf_q.push_back(tl[7:0]);
		end else if (proto == PROTO_IPV6) begin
			buf_q.push_back({4'h6, 4'($urandom)});
			repeat (3) buf_q.push_back(8'($urandom));
			buf_q.push_back(tl[15:8]);
			buf_q.push_back(tl[7:0]);
		end
		repeat ($urandom_range(0, 3)) buf_q.push_back(8'($urandom));
		buf_len = (cap > 65535) ? 16'hFFFF : 16'(cap);
	endfunction

	task automatic test_short_buffers();
		wait_idle();
		write_mode(1'b0);
		buf_q = '{8'hFF};
		buf_len = 16'd0;
		send_buffer(1'b1);
		buf_q = '{8'h00, 8'h01, 8'hFF, 8'hFF};
		buf_len = 16'd4;
		send_buffer(1'b1);
		buf_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		buf_len = 16'd3;
		send_buffer(1'b1);
		buf_q = '{8'h12, 8'h34};
		buf_len = 16'd100;
		send_buffer(1'b1);
		buf_q = '{8'h55, 8'hAA, 8'h55, 8'hAA};
		buf_len = 16'd15;
		send_buffer(1'b1);
	endtask

	task automatic test_zero_completion();
		wait_idle();
		write_mode(1'b1);
		buf_q = '{8'h00, 8'h00, 8'h00, 8'h00};
		buf_len = 16'd4;
		send_buffer(1'b1);
		buf_q = '{8'h00, 8'h01, 8'h00, 8'h00};
		send_buffer(1'b1);
		build_ncm(0, 1'b1, MIN_BLOCK, 60);
		send_buffer(1'b1);
	endtask

	task automatic test_ncm_blocks();
		wait_idle();
		write_mode(1'b1);
		build_ncm(1, 1'b1, MIN_BLOCK, 65535);
		send_buffer(1'b1);
		// second entry points into the header
		build_ncm(2, 1'b1, 300, 300);
		buf_q[24] = 8'h10;
		buf_q[25] = 8'h00;
		send_buffer(1'b1);
		build_ncm(2, 1'b0, 400, 500);
		send_buffer(1'b1);
		build_ncm(MAX_ENTRIES_DEF, 1'b1, 2000, 4000);
		send_buffer(1'b1);
	endtask

	task automatic test_legacy_frames();
		wait_idle();
		write_mode(1'b0);
		build_legacy(PROTO_ARP, 0, 0);
		send_buffer(1'b1);
		build_legacy(PROTO_IPV4, 0, 0);
		send_buffer(1'b1);
		build_legacy(PROTO_IPV6, 1000, 5);
		send_buffer(1'b1);
		build_legacy(PROTO_OTHER, 0, 0);
		send_buffer(1'b1);
	endtask

	task automatic test_random_traffic();
		int unsigned sent, buffers, cut, entries, blk, cap, payload, slack;
		sent = 0;
		buffers = 0;
		while (sent < RANDOM_ITEMS) begin
			if (buffers % 6 == 0) begin
				wait_idle();
				write_mode($urandom_range(0, 1));
				rx_idle_on = $urandom_range(0, 3) != 0;
				res_stall_on = $urandom_range(0, 3) != 0;
			end else if ($urandom_range(0, 9) == 0) begin
				wait_idle();
			end
			if ($urandom_range(0, 19) == 0) begin
				buf_q = '{8'h00, 8'h00, 8'h00, 8'h00};
				if ($urandom_range(0, 1)) buf_q[1] = 8'h01;
				buf_len = 16'($urandom_range(0, 8));
			end else if (mode_shadow == ($urandom_range(0, 6) != 0)) begin
				if ($urandom_range(0, 9) == 0) entries = MAX_ENTRIES_DEF;
				else if ($urandom_range(0, 3) == 0) entries = $urandom_range(0, MAX_ENTRIES_DEF);
				else entries = $urandom_range(0, 3);
				if ($urandom_range(0, 7) == 0) blk = $urandom_range(MIN_BLOCK, 65535);
				else blk = $urandom_range(MIN_BLOCK, 600);
				cap = $urandom_range(0, 1) ? blk : $urandom_range(blk, 65535);
				build_ncm(entries, $urandom_range(0, 5) != 0, blk, cap);
			end else begin
				if ($urandom_range(0, 5) == 0) payload = $urandom_range(0, 65000);
				else payload = $urandom_range(0, 1500);
				slack = $urandom_range(0, 1) ? 0 : $urandom_range(0, 64);
				build_legacy(frame_proto_t'($urandom_range(0, 3)), payload, slack);
			end
			if ($urandom_range(0, 6) == 0)
				buf_q[$urandom_range(0, buf_q.size() - 1)] ^= 8'($urandom_range(1, 255));
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(1, buf_q.size());
				while (buf_q.size() > cut) void'(buf_q.pop_back());
			end
			send_buffer(1'b1);
			sent += buf_q.size();
			buffers++;
		end
		rx_idle_on = 1'b1;
		res_stall_on = 1'b1;
	endtask

	// IPv6 header cut short, then NCM mode with no table: the buffer stays undecided until its last byte
	task automatic test_stuck_position();
		wait_idle();
		write_mode(1'b0);
		build_legacy(PROTO_IPV6, 100, 0);
		while (buf_q.size() > 19) void'(buf_q.pop_back());
		send_buffer(1'b0);
		wait_idle();
		write_mode(1'b1);
		rx_idle_on = 1'b0;
		repeat (STUCK_BYTES) send_byte(8'h00, buf_len, 1'b0);
		send_byte(8'h00, buf_len, 1'b1);
		rx_idle_on = 1'b1;
	endtask

	initial begin
		rx_if.valid <= 1'b0;
		rx_if.data_byte <= '0;
		rx_if.buffer_length <= '0;
		rx_if.last_byte <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.ncm_mode <= 1'b0;
		arst_n <= 1'b0;
		rx_idle_on = 1'b1;
		res_stall_on = 1'b1;
		mode_shadow = 1'b0;
		clear_parser();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_buffers();
		test_zero_completion();
		test_ncm_blocks();
		test_legacy_frames();
		test_random_traffic();
		test_stuck_position();
		wait_idle();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
